// ===== sv/cdo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cdo_pkg;

  // Field widths of the date and the status.
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int STATUS_W = 2;

  // Default width of the day count.
  localparam int OFFSET_WIDTH_DEF = 16;

  // Calendar limits.
  localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [DAY_W-1:0]   DAYS_SHORT = 5'd28;
  localparam logic [DAY_W-1:0]   DAYS_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0]   DAYS_MID   = 5'd30;
  localparam logic [DAY_W-1:0]   DAYS_LONG  = 5'd31;

  // Year divided by 100 as a multiply by 5243 / 2^19, exact for 14-bit years.
  localparam int               RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int               RECIP_SHIFT = 19;
  localparam int               PROD_W      = YEAR_W + RECIP_W;
  localparam int               CENT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [YEAR_W:0]  CENT_MULT   = 15'd100;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  // Microcode operations.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_IDLE  = 3'd0;
  localparam logic [OP_W-1:0] OP_CALCQ = 3'd1;
  localparam logic [OP_W-1:0] OP_CALCL = 3'd2;
  localparam logic [OP_W-1:0] OP_CHECK = 3'd3;
  localparam logic [OP_W-1:0] OP_FWD   = 3'd4;
  localparam logic [OP_W-1:0] OP_BWD   = 3'd5;
  localparam logic [OP_W-1:0] OP_DONE  = 3'd6;

  // Microcode addresses.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] A_START   = 4'd0;
  localparam logic [PC_W-1:0] A_LEAP0   = 4'd1;
  localparam logic [PC_W-1:0] A_CHECK   = 4'd2;
  localparam logic [PC_W-1:0] A_FWD     = 4'd3;
  localparam logic [PC_W-1:0] A_FWD_Q   = 4'd4;
  localparam logic [PC_W-1:0] A_FWD_L   = 4'd5;
  localparam logic [PC_W-1:0] A_BWD     = 4'd6;
  localparam logic [PC_W-1:0] A_BWD_Q   = 4'd7;
  localparam logic [PC_W-1:0] A_BWD_L   = 4'd8;
  localparam logic [PC_W-1:0] A_DONE    = 4'd9;
  localparam logic [PC_W-1:0] A_IDLE    = 4'd10;

  // One control word: operation, sequential successor and branch target.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [PC_W-1:0] seq;
    logic [PC_W-1:0] jmp;
  } uword_t;

  // Conditions reported by the datapath to the sequencer.
  typedef struct packed {
    logic invalid;
    logic sub;
    logic rem_zero;
    logic year_wrap;
    logic year_out;
  } flags_t;

  // One result item.
  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [STATUS_W-1:0] status;
  } res_t;

  // Control program.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_IDLE, seq: A_IDLE, jmp: A_IDLE};
    case (pc)
      A_START: w = '{op: OP_CALCQ, seq: A_LEAP0, jmp: A_LEAP0};
      A_LEAP0: w = '{op: OP_CALCL, seq: A_CHECK, jmp: A_CHECK};
      A_CHECK: w = '{op: OP_CHECK, seq: A_FWD,   jmp: A_BWD};
      A_FWD:   w = '{op: OP_FWD,   seq: A_FWD_Q, jmp: A_FWD};
      A_FWD_Q: w = '{op: OP_CALCQ, seq: A_FWD_L, jmp: A_FWD_L};
      A_FWD_L: w = '{op: OP_CALCL, seq: A_FWD,   jmp: A_FWD};
      A_BWD:   w = '{op: OP_BWD,   seq: A_BWD_Q, jmp: A_BWD};
      A_BWD_Q: w = '{op: OP_CALCQ, seq: A_BWD_L, jmp: A_BWD_L};
      A_BWD_L: w = '{op: OP_CALCL, seq: A_BWD,   jmp: A_BWD};
      A_DONE:  w = '{op: OP_DONE,  seq: A_IDLE,  jmp: A_IDLE};
      A_IDLE:  w = '{op: OP_IDLE,  seq: A_IDLE,  jmp: A_START};
      default: w = '{op: OP_IDLE,  seq: A_IDLE,  jmp: A_IDLE};
    endcase
    return w;
  endfunction

  // Days in a month; zero for a month number outside the calendar.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] d;
    d = '0;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAYS_LONG;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = DAYS_MID;
      4'd2:    d = leap ? DAYS_LEAP : DAYS_SHORT;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== sv/cdo_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Request channel carrying a start date and a day count.
interface cdo_in_if #(
  parameter int OFFSET_WIDTH = cdo_pkg::OFFSET_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [cdo_pkg::YEAR_W-1:0]   start_year;
  logic [cdo_pkg::MONTH_W-1:0]  start_month;
  logic [cdo_pkg::DAY_W-1:0]    start_day;
  logic [OFFSET_WIDTH-1:0]      day_offset;

  modport source (output valid, func, start_year, start_month, start_day, day_offset,
                  input ready);
  modport sink (input valid, func, start_year, start_month, start_day, day_offset,
                output ready);
endinterface

// Result channel carrying the shifted date and its status.
interface cdo_out_if ();
  logic                         valid;
  logic                         ready;
  logic [cdo_pkg::YEAR_W-1:0]   result_year;
  logic [cdo_pkg::MONTH_W-1:0]  result_month;
  logic [cdo_pkg::DAY_W-1:0]    result_day;
  logic [cdo_pkg::STATUS_W-1:0] status;

  modport source (output valid, result_year, result_month, result_day, status,
                  input ready);
  modport sink (input valid, result_year, result_month, result_day, status,
                output ready);
endinterface
`default_nettype wire

// ===== sv/calendar_date_day_offset.sv =====
// A request runs the century quotient, leap test and date check, then (if the date is valid)
// datapath steps, with quotient and leap test redone per year entered; a step crosses one
// month or uses up the count, and a last step finds it spent unless the year leaves the range.
// Throughput: one request at a time; the next request is taken once the result sits in the
// output register, while it waits for the sink.
// Reset (synchronous, rst high) returns the sequencer to idle and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module calendar_date_day_offset #(
  parameter int OFFSET_WIDTH = cdo_pkg::OFFSET_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  cdo_in_if.sink   in_ch,
  cdo_out_if.source out_ch
);

  cdo_pkg::uword_t ctrl;
  cdo_pkg::flags_t flags;
  cdo_pkg::res_t   res;
  cdo_pkg::res_t   out_reg;
  logic            out_valid;
  logic            out_free;
  logic            start;

  // Request handshake: taken only while the sequencer is idle.
  assign in_ch.ready = (ctrl.op == cdo_pkg::OP_IDLE);
  assign start       = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  cdo_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  cdo_datapath #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .start       (start),
    .func        (in_ch.func),
    .start_year  (in_ch.start_year),
    .start_month (in_ch.start_month),
    .start_day   (in_ch.start_day),
    .day_offset  (in_ch.day_offset),
    .op          (ctrl.op),
    .flags       (flags),
    .res         (res)
  );

  // Output register, loaded at the final step of the program.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == cdo_pkg::OP_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == cdo_pkg::OP_DONE && out_free) begin
      out_reg <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.result_year  = out_reg.year;
  assign out_ch.result_month = out_reg.month;
  assign out_ch.result_day   = out_reg.day;
  assign out_ch.status       = out_reg.status;

  // An accepted request always starts the program at its first step.
  a_start_fetch: assert property (@(posedge clk) disable iff (rst)
    start |=> (ctrl.op == cdo_pkg::OP_CALCQ))
    else $error("request did not start the program");

  // A result appears only after the final program step.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.op == cdo_pkg::OP_DONE))
    else $error("result appeared without a final step");

  // A good result always carries a calendar month.
  a_ok_month: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.status == cdo_pkg::ST_OK) |->
      (out_reg.month >= cdo_pkg::MONTH_JAN && out_reg.month <= cdo_pkg::MONTH_DEC))
    else $error("good result with a bad month");

endmodule
`default_nettype wire

// ===== sv/cdo_useq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cdo_useq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            out_free,
  input  wire cdo_pkg::flags_t flags,
  output cdo_pkg::uword_t      ctrl
);

  logic [cdo_pkg::PC_W-1:0] pc;
  logic [cdo_pkg::PC_W-1:0] pc_next;

  // Fetch the control word of the current step.
  assign ctrl = cdo_pkg::ucode_rom(pc);

  // Pick the next step from the operation and the datapath conditions.
  always_comb begin
    pc_next = pc;
    unique case (ctrl.op)
      cdo_pkg::OP_IDLE: begin
        pc_next = start ? ctrl.jmp : pc;
      end
      cdo_pkg::OP_CALCQ, cdo_pkg::OP_CALCL: begin
        pc_next = ctrl.seq;
      end
      cdo_pkg::OP_CHECK: begin
        if (flags.invalid) begin
          pc_next = cdo_pkg::A_DONE;
        end else if (flags.sub) begin
          pc_next = ctrl.jmp;
        end else begin
          pc_next = ctrl.seq;
        end
      end
      cdo_pkg::OP_FWD, cdo_pkg::OP_BWD: begin
        if (flags.rem_zero || (flags.year_wrap && flags.year_out)) begin
          pc_next = cdo_pkg::A_DONE;
        end else if (flags.year_wrap) begin
          pc_next = ctrl.seq;
        end else begin
          pc_next = ctrl.jmp;
        end
      end
      cdo_pkg::OP_DONE: begin
        pc_next = out_free ? ctrl.seq : pc;
      end
      default: begin
        pc_next = cdo_pkg::A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= cdo_pkg::A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/cdo_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cdo_datapath #(
  parameter int OFFSET_WIDTH = cdo_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        start,
  input  wire logic                        func,
  input  wire logic [cdo_pkg::YEAR_W-1:0]  start_year,
  input  wire logic [cdo_pkg::MONTH_W-1:0] start_month,
  input  wire logic [cdo_pkg::DAY_W-1:0]   start_day,
  input  wire logic [OFFSET_WIDTH-1:0]     day_offset,
  input  wire logic [cdo_pkg::OP_W-1:0]    op,
  output cdo_pkg::flags_t                  flags,
  output cdo_pkg::res_t                    res
);

  localparam int OW = OFFSET_WIDTH;

  // Working date, remaining days and the saved input date.
  logic                          sub;
  logic [cdo_pkg::YEAR_W-1:0]    y;
  logic [cdo_pkg::MONTH_W-1:0]   m;
  logic [cdo_pkg::DAY_W-1:0]     d;
  logic [OW-1:0]                 rem;
  logic [cdo_pkg::YEAR_W-1:0]    y0;
  logic [cdo_pkg::MONTH_W-1:0]   m0;
  logic [cdo_pkg::DAY_W-1:0]     d0;
  logic [cdo_pkg::STATUS_W-1:0]  status;
  logic [cdo_pkg::CENT_W-1:0]    q;
  logic                          leap;

  logic [cdo_pkg::PROD_W-1:0]    prod;
  logic [cdo_pkg::YEAR_W:0]      cent_back;
  logic [cdo_pkg::DAY_W-1:0]     dim;
  logic [cdo_pkg::DAY_W-1:0]     dim_prev;
  logic [OW:0]                   fwd_sum;
  logic                          fwd_over;
  logic [cdo_pkg::DAY_W:0]       fwd_used;
  logic                          bwd_ge;
  logic                          invalid;

  // Century quotient by reciprocal multiply, and its product back for the leap test.
  assign prod      = cdo_pkg::PROD_W'(y) * cdo_pkg::PROD_W'(cdo_pkg::RECIP_100);
  assign cent_back = (cdo_pkg::YEAR_W + 1)'(q) * cdo_pkg::CENT_MULT;

  // Month lengths of the current and the previous month.
  assign dim      = cdo_pkg::month_days(m, leap);
  assign dim_prev = cdo_pkg::month_days(m - 4'd1, leap);

  // A forward step leaves the month when the day plus the remainder passes its end.
  assign fwd_sum  = {1'b0, rem} + {{(OW - 4){1'b0}}, d};
  assign fwd_over = fwd_sum > {{(OW - 4){1'b0}}, dim};
  assign fwd_used = {1'b0, dim} - {1'b0, d} + 6'd1;
  assign bwd_ge   = rem >= {{(OW - 5){1'b0}}, d};

  // Input date check.
  assign invalid = (y < cdo_pkg::YEAR_MIN) || (y > cdo_pkg::YEAR_MAX) ||
                   (m < cdo_pkg::MONTH_JAN) || (m > cdo_pkg::MONTH_DEC) ||
                   (d == '0) || (d > dim);

  // Conditions for the sequencer.
  always_comb begin
    flags.invalid  = invalid;
    flags.sub      = sub;
    flags.rem_zero = (rem == '0);
    if (sub) begin
      flags.year_wrap = bwd_ge && (m == cdo_pkg::MONTH_JAN);
      flags.year_out  = (y == cdo_pkg::YEAR_MIN);
    end else begin
      flags.year_wrap = fwd_over && (m == cdo_pkg::MONTH_DEC);
      flags.year_out  = (y == cdo_pkg::YEAR_MAX);
    end
  end

  // Result fields: the input date comes back on any error.
  always_comb begin
    res.status = status;
    if (status != cdo_pkg::ST_OK) begin
      res.year  = y0;
      res.month = m0;
      res.day   = d0;
    end else begin
      res.year  = y;
      res.month = m;
      res.day   = d;
    end
  end

  // Datapath registers, driven by the operation of the current step.
  always_ff @(posedge clk) begin
    if (start) begin
      sub    <= func;
      y      <= start_year;
      m      <= start_month;
      d      <= start_day;
      y0     <= start_year;
      m0     <= start_month;
      d0     <= start_day;
      rem    <= day_offset;
      status <= cdo_pkg::ST_OK;
    end else begin
      case (op)
        cdo_pkg::OP_CALCQ: begin
          q <= prod[cdo_pkg::RECIP_SHIFT +: cdo_pkg::CENT_W];
        end
        cdo_pkg::OP_CALCL: begin
          leap <= (y[1:0] == 2'b00) &&
                  (({1'b0, y} != cent_back) || (q[1:0] == 2'b00));
        end
        cdo_pkg::OP_CHECK: begin
          if (invalid) begin
            status <= cdo_pkg::ST_INVALID;
          end
        end
        cdo_pkg::OP_FWD: begin
          if (rem != '0) begin
            if (fwd_over) begin
              rem <= rem - {{(OW - 6){1'b0}}, fwd_used};
              d   <= 5'd1;
              if (m == cdo_pkg::MONTH_DEC) begin
                m <= cdo_pkg::MONTH_JAN;
                y <= y + 14'd1;
                if (y == cdo_pkg::YEAR_MAX) begin
                  status <= cdo_pkg::ST_RANGE;
                end
              end else begin
                m <= m + 4'd1;
              end
            end else begin
              d   <= d + rem[cdo_pkg::DAY_W-1:0];
              rem <= '0;
            end
          end
        end
        cdo_pkg::OP_BWD: begin
          if (rem != '0) begin
            if (bwd_ge) begin
              rem <= rem - {{(OW - 5){1'b0}}, d};
              if (m == cdo_pkg::MONTH_JAN) begin
                m <= cdo_pkg::MONTH_DEC;
                y <= y - 14'd1;
                d <= cdo_pkg::DAYS_LONG;
                if (y == cdo_pkg::YEAR_MIN) begin
                  status <= cdo_pkg::ST_RANGE;
                end
              end else begin
                m <= m - 4'd1;
                d <= dim_prev;
              end
            end else begin
              d   <= d - rem[cdo_pkg::DAY_W-1:0];
              rem <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sim/calendar_date_day_offset_tb.sv =====
`timescale 1ns / 1ps
module calendar_date_day_offset_tb;

  localparam int OFFSET_W = cdo_pkg::OFFSET_WIDTH_DEF;

  // Calendar limits as plain integers for the predictor.
  localparam int unsigned YEAR_LO  = 32'(cdo_pkg::YEAR_MIN);
  localparam int unsigned YEAR_HI  = 32'(cdo_pkg::YEAR_MAX);
  localparam int unsigned MONTH_LO = 32'(cdo_pkg::MONTH_JAN);
  localparam int unsigned MONTH_HI = 32'(cdo_pkg::MONTH_DEC);

  // Operation select on the request channel.
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_SUB = 1'b1;

  // One directed request; the expected date is given only where it is obvious.
  typedef struct packed {
    logic                         op;
    logic [cdo_pkg::YEAR_W-1:0]   year;
    logic [cdo_pkg::MONTH_W-1:0]  month;
    logic [cdo_pkg::DAY_W-1:0]    day;
    logic [OFFSET_W-1:0]          offset;
    logic                         known;
    cdo_pkg::res_t                want;
  } date_case_t;

  localparam cdo_pkg::res_t NO_RESULT = '0;
  localparam int N_DIRECTED = 25;

  localparam date_case_t DIRECTED [N_DIRECTED] = '{
    // Zero offsets return the date unchanged.
    '{FUNC_ADD, 14'd2024, 4'd2, 5'd29, 16'd0, 1'b1,
      '{14'd2024, 4'd2, 5'd29, cdo_pkg::ST_OK}},
    '{FUNC_SUB, 14'd1, 4'd1, 5'd1, 16'd0, 1'b1, '{14'd1, 4'd1, 5'd1, cdo_pkg::ST_OK}},
    // Stepping past either end of the year range.
    '{FUNC_SUB, 14'd1, 4'd1, 5'd1, 16'd1, 1'b1, '{14'd1, 4'd1, 5'd1, cdo_pkg::ST_RANGE}},
    '{FUNC_ADD, 14'd9999, 4'd12, 5'd31, 16'd1, 1'b1,
      '{14'd9999, 4'd12, 5'd31, cdo_pkg::ST_RANGE}},
    '{FUNC_ADD, 14'd9999, 4'd1, 5'd1, 16'hFFFF, 1'b1,
      '{14'd9999, 4'd1, 5'd1, cdo_pkg::ST_RANGE}},
    '{FUNC_SUB, 14'd1, 4'd12, 5'd31, 16'hFFFF, 1'b1,
      '{14'd1, 4'd12, 5'd31, cdo_pkg::ST_RANGE}},
    // Invalid start dates come back as they went in.
    '{FUNC_ADD, 14'd0, 4'd1, 5'd1, 16'd5, 1'b1, '{14'd0, 4'd1, 5'd1, cdo_pkg::ST_INVALID}},
    '{FUNC_SUB, 14'd10000, 4'd6, 5'd15, 16'd100, 1'b1,
      '{14'd10000, 4'd6, 5'd15, cdo_pkg::ST_INVALID}},
    '{FUNC_SUB, 14'h3FFF, 4'hF, 5'h1F, 16'hFFFF, 1'b1,
      '{14'h3FFF, 4'hF, 5'h1F, cdo_pkg::ST_INVALID}},
    '{FUNC_ADD, 14'd2024, 4'd0, 5'd10, 16'd1, 1'b1,
      '{14'd2024, 4'd0, 5'd10, cdo_pkg::ST_INVALID}},
    '{FUNC_ADD, 14'd2024, 4'd13, 5'd1, 16'd1, 1'b1,
      '{14'd2024, 4'd13, 5'd1, cdo_pkg::ST_INVALID}},
    '{FUNC_SUB, 14'd2024, 4'd5, 5'd0, 16'd1, 1'b1,
      '{14'd2024, 4'd5, 5'd0, cdo_pkg::ST_INVALID}},
    '{FUNC_ADD, 14'd2024, 4'd2, 5'd30, 16'd1, 1'b1,
      '{14'd2024, 4'd2, 5'd30, cdo_pkg::ST_INVALID}},
    '{FUNC_ADD, 14'd2023, 4'd2, 5'd29, 16'd1, 1'b1,
      '{14'd2023, 4'd2, 5'd29, cdo_pkg::ST_INVALID}},
    '{FUNC_SUB, 14'd2023, 4'd4, 5'd31, 16'd1, 1'b1,
      '{14'd2023, 4'd4, 5'd31, cdo_pkg::ST_INVALID}},
    // Month and year boundaries and the leap-year rules.
    '{FUNC_ADD, 14'd2023, 4'd12, 5'd31, 16'd1, 1'b0, NO_RESULT},
    '{FUNC_ADD, 14'd2024, 4'd2, 5'd28, 16'd1, 1'b0, NO_RESULT},
    '{FUNC_ADD, 14'd1900, 4'd2, 5'd28, 16'd1, 1'b0, NO_RESULT},
    '{FUNC_ADD, 14'd2000, 4'd2, 5'd28, 16'd1, 1'b0, NO_RESULT},
    '{FUNC_ADD, 14'd2100, 4'd2, 5'd28, 16'd1, 1'b0, NO_RESULT},
    '{FUNC_SUB, 14'd2024, 4'd3, 5'd1, 16'd1, 1'b0, NO_RESULT},
    '{FUNC_SUB, 14'd2000, 4'd1, 5'd1, 16'd1, 1'b0, NO_RESULT},
    '{FUNC_ADD, 14'd2024, 4'd1, 5'd31, 16'd31, 1'b0, NO_RESULT},
    // Largest day counts from the ends of the range.
    '{FUNC_ADD, 14'd1, 4'd1, 5'd1, 16'hFFFF, 1'b0, NO_RESULT},
    '{FUNC_SUB, 14'd9999, 4'd12, 5'd31, 16'hFFFF, 1'b0, NO_RESULT}
  };

  logic          clk;
  logic          rst;
  logic          steady;
  int            error_count = 0;
  cdo_pkg::res_t pending_dates[$];

  cdo_in_if #(.OFFSET_WIDTH(OFFSET_W)) in_ch ();
  cdo_out_if out_ch ();

  calendar_date_day_offset #(.OFFSET_WIDTH(OFFSET_W)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gregorian leap year: every fourth year, except centuries not divisible by 400.
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // Length of a valid month in days.
  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    int unsigned n;
    case (m)
      4, 6, 9, 11:              n = 32'(cdo_pkg::DAYS_MID);
      32'(cdo_pkg::MONTH_FEB):  n = leap_year(y) ? 32'(cdo_pkg::DAYS_LEAP) :
                                                   32'(cdo_pkg::DAYS_SHORT);
      default:                  n = 32'(cdo_pkg::DAYS_LONG);
    endcase
    return n;
  endfunction

  // Expected shifted date, walking one month at a time.
  function automatic cdo_pkg::res_t predict_shift(input logic op,
                                                  input logic [cdo_pkg::YEAR_W-1:0] yr,
                                                  input logic [cdo_pkg::MONTH_W-1:0] mo,
                                                  input logic [cdo_pkg::DAY_W-1:0] dy,
                                                  input logic [OFFSET_W-1:0] off);
    int unsigned     y, m, d, span;
    longint unsigned left;
    cdo_pkg::res_t   r;
    y = 32'(yr);
    m = 32'(mo);
    d = 32'(dy);
    left = 64'(off);
    r = '{year: yr, month: mo, day: dy, status: cdo_pkg::ST_OK};
    if (y < YEAR_LO || y > YEAR_HI || m < MONTH_LO || m > MONTH_HI ||
        d < 1 || d > month_length(y, m)) begin
      r.status = cdo_pkg::ST_INVALID;
      return r;
    end
    while (left > 0) begin
      if (op == FUNC_ADD) begin
        // Jump to the 1st of the next month when the count runs past this one.
        span = month_length(y, m);
        if (64'(d) + left > 64'(span)) begin
          left -= 64'(span - d + 1);
          d = 1;
          m++;
          if (m > MONTH_HI) begin
            m = MONTH_LO;
            y++;
            if (y > YEAR_HI) begin
              r.status = cdo_pkg::ST_RANGE;
              return r;
            end
          end
        end else begin
          d += 32'(left);
          left = 0;
        end
      end else begin
        // Drop back to the last day of the previous month.
        if (left >= 64'(d)) begin
          left -= 64'(d);
          m--;
          if (m < MONTH_LO) begin
            m = MONTH_HI;
            y--;
            if (y < YEAR_LO) begin
              r.status = cdo_pkg::ST_RANGE;
              return r;
            end
          end
          d = month_length(y, m);
        end else begin
          d -= 32'(left);
          left = 0;
        end
      end
    end
    r.year = y[cdo_pkg::YEAR_W-1:0];
    r.month = m[cdo_pkg::MONTH_W-1:0];
    r.day = d[cdo_pkg::DAY_W-1:0];
    return r;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Drive one request at the falling edge and hold it until it is taken.
  task automatic send_request(input logic op, input logic [cdo_pkg::YEAR_W-1:0] yr,
                              input logic [cdo_pkg::MONTH_W-1:0] mo,
                              input logic [cdo_pkg::DAY_W-1:0] dy,
                              input logic [OFFSET_W-1:0] off, input logic known,
                              input cdo_pkg::res_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= op;
    in_ch.start_year  <= yr;
    in_ch.start_month <= mo;
    in_ch.start_day   <= dy;
    in_ch.day_offset  <= off;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_dates.push_back(known ? want : predict_shift(op, yr, mo, dy, off));
    @(negedge clk);
  endtask

  // Result sink with random back-pressure.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest expected date.
  always @(posedge clk) begin : result_check
    cdo_pkg::res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected result %0d-%0d-%0d status %0d", out_ch.result_year,
               out_ch.result_month, out_ch.result_day, out_ch.status);
        error_count++;
      end else begin
        want = pending_dates.pop_front();
        if (out_ch.result_year !== want.year) begin
          $error("result_year: expected %0d, got %0d", want.year, out_ch.result_year);
          error_count++;
        end
        if (out_ch.result_month !== want.month) begin
          $error("result_month: expected %0d, got %0d", want.month, out_ch.result_month);
          error_count++;
        end
        if (out_ch.result_day !== want.day) begin
          $error("result_day: expected %0d, got %0d", want.day, out_ch.result_day);
          error_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          error_count++;
        end
      end
    end
  end

  // Stimulus: directed table, then random requests.
  initial begin
    logic                         op;
    logic [cdo_pkg::YEAR_W-1:0]   yr;
    logic [cdo_pkg::MONTH_W-1:0]  mo;
    logic [cdo_pkg::DAY_W-1:0]    dy;
    logic [OFFSET_W-1:0]          off;
    int                           pick;
    steady            = 1'b0;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_ADD;
    in_ch.start_year  = '0;
    in_ch.start_month = '0;
    in_ch.start_day   = '0;
    in_ch.day_offset  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      send_request(DIRECTED[i].op, DIRECTED[i].year, DIRECTED[i].month, DIRECTED[i].day,
                   DIRECTED[i].offset, DIRECTED[i].known, DIRECTED[i].want);
    end

    for (int i = 0; i < 245; i++) begin
      // Every fourth block of thirty requests runs without idling on either side.
      steady = ((i / 30) % 4) == 3;
      op = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        // Well-formed date, often close to one end of the year range.
        pick = $urandom_range(0, 99);
        if (pick < 70) yr = cdo_pkg::YEAR_W'($urandom_range(1, 9999));
        else if (pick < 85) yr = cdo_pkg::YEAR_W'($urandom_range(1, 150));
        else yr = cdo_pkg::YEAR_W'($urandom_range(9850, 9999));
        mo = cdo_pkg::MONTH_W'($urandom_range(1, 12));
        dy = cdo_pkg::DAY_W'($urandom_range(1, month_length(32'(yr), 32'(mo))));
        pick = $urandom_range(0, 99);
        if (pick < 5) off = OFFSET_W'($urandom_range(0, 3));
        else if (pick < 60) off = OFFSET_W'($urandom_range(0, 400));
        else if (pick < 85) off = OFFSET_W'($urandom_range(0, 5000));
        else off = OFFSET_W'($urandom_range(0, 65535));
      end else begin
        // Raw field values, mostly invalid dates.
        yr  = cdo_pkg::YEAR_W'($urandom_range(0, 16383));
        mo  = cdo_pkg::MONTH_W'($urandom_range(0, 15));
        dy  = cdo_pkg::DAY_W'($urandom_range(0, 31));
        off = OFFSET_W'($urandom_range(0, 65535));
      end
      send_request(op, yr, mo, dy, off, 1'b0, NO_RESULT);
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain, then watch long enough for a stray result to show up.
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (2600) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
